// ----- rtl/core/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the byte ring fifo core
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DATA_W     = 8;
    localparam int CNT_OUT_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [7:0] CAP_RESET = 8'hFF;
    localparam logic [7:0] TALLY_MAX = 8'hFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic clear;   // empty the whole row
        logic shift;   // accepted read, every cell takes its right neighbor
        logic load;    // accepted write, first free cell takes the byte
    } cell_ctl_t;

    typedef struct packed {
        logic                 accepted;
        logic [DATA_W-1:0]    read_data;
        logic [CNT_OUT_W-1:0] stored_count;
        logic [CNT_OUT_W-1:0] free_count;
        logic                 is_empty;
        logic                 is_full;
        logic [CNT_OUT_W-1:0] moved_in_request;
    } rsp_t;

endpackage

// ----- rtl/core/brf_if.sv -----
// ----------------------------------------------------------------------------
// brf_if
// valid/ready channels of the byte ring fifo core
// ----------------------------------------------------------------------------
interface brf_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] write_data;
    logic       last_of_request;

    modport source (output valid, output operation, output write_data,
                    output last_of_request, input ready);
    modport sink   (input valid, input operation, input write_data,
                    input last_of_request, output ready);
endinterface

interface brf_rsp_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [7:0] read_data;
    logic [7:0] stored_count;
    logic [7:0] free_count;
    logic       is_empty;
    logic       is_full;
    logic [7:0] moved_in_request;

    modport source (output valid, output accepted, output read_data,
                    output stored_count, output free_count, output is_empty,
                    output is_full, output moved_in_request, input ready);
    modport sink   (input valid, input accepted, input read_data,
                    input stored_count, input free_count, input is_empty,
                    input is_full, input moved_in_request, output ready);
endinterface

// ----- rtl/core/byte_ring_fifo_core.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_core
// byte fifo with run-time capacity, built as a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   req: one word per byte operation (operation: 0 write, 1 read), with the
//     byte to store and a last marker that closes the current request
//   rsp: one word per req word: accepted flag, byte read, stored and free
//     counts, empty/full flags and the bytes moved so far in the request
//   apb: register 0 (byte address 0) is capacity; writing it empties the fifo
//     and clears the request tally, capacity 0 refuses every operation
//   output: each rsp word is registered in the result buffer before it shows
//   throughput: one word per cycle while req.ready is high; each byte cell
//     updates from its left/right neighbors, so the row sets the pace, not a
//     memory port
//   stall: a two-entry result buffer lets req be taken while one rsp word
//     waits; req.ready drops only when both entries are full
//   reset: fifo empty, tally zero, capacity 255; req.ready rises from a
//     registered up flag that sets once rst_n is released
//   a read takes the head cell and every cell shifts one place toward it;
//   a write fills the first empty cell behind the last filled one
// ----------------------------------------------------------------------------
module byte_ring_fifo_core #(
    parameter int MAX_CAPACITY = 255
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    brf_req_if.sink                          req,
    brf_rsp_if.source                        rsp
);

    // one cell per usable byte
    localparam int NCELL = MAX_CAPACITY;

    brf_pkg::cell_ctl_t            cell_ctl;
    brf_pkg::rsp_t                 rsp_word;
    logic                          rsp_valid;
    logic                          req_ready;
    logic [NCELL-1:0]              cell_valid;
    logic [brf_pkg::DATA_W-1:0]    cell_data [NCELL];

    assign pready = 1'b1;

    brf_ctrl #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .req_valid     (req.valid),
        .req_operation (req.operation),
        .req_last      (req.last_of_request),
        .req_ready     (req_ready),
        .head_data     (cell_data[0]),
        .cell_ctl      (cell_ctl),
        .rsp           (rsp_word),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp.ready)
    );

    // the cell row: head at index 0, tail grows upward
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        logic                       prev_valid;
        logic                       next_valid;
        logic [brf_pkg::DATA_W-1:0] next_data;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = cell_valid[i-1];
        end

        if (i == NCELL - 1)
        begin : g_end
            assign next_valid = 1'b0;
            assign next_data  = '0;
        end
        else
        begin : g_link
            assign next_valid = cell_valid[i+1];
            assign next_data  = cell_data[i+1];
        end

        brf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .write_data (req.write_data),
            .prev_valid (prev_valid),
            .next_valid (next_valid),
            .next_data  (next_data),
            .valid      (cell_valid[i]),
            .data       (cell_data[i])
        );
    end

    assign req.ready            = req_ready;
    assign rsp.valid            = rsp_valid;
    assign rsp.accepted         = rsp_word.accepted;
    assign rsp.read_data        = rsp_word.read_data;
    assign rsp.stored_count     = rsp_word.stored_count;
    assign rsp.free_count       = rsp_word.free_count;
    assign rsp.is_empty         = rsp_word.is_empty;
    assign rsp.is_full          = rsp_word.is_full;
    assign rsp.moved_in_request = rsp_word.moved_in_request;

endmodule

// ----- rtl/core/brf_cell.sv -----
// ----------------------------------------------------------------------------
// brf_cell
// one byte slot of the fifo row, fed from its right neighbor on reads
// ----------------------------------------------------------------------------
module brf_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  brf_pkg::cell_ctl_t           ctl,
    input  logic [brf_pkg::DATA_W-1:0]   write_data,
    input  logic                         prev_valid,
    input  logic                         next_valid,
    input  logic [brf_pkg::DATA_W-1:0]   next_data,
    output logic                         valid,
    output logic [brf_pkg::DATA_W-1:0]   data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [brf_pkg::DATA_W-1:0] data_reg;
    logic [brf_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctl.load && !valid_reg && prev_valid)
        begin
            // tail cell: first empty slot after a filled one, or the head cell when the row is empty
            valid_next = 1'b1;
            data_next  = write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- rtl/core/brf_ctrl.sv -----
// ----------------------------------------------------------------------------
// brf_ctrl
// capacity register, fill count, request tally and result buffer
// ----------------------------------------------------------------------------
module brf_ctrl #(
    parameter int MAX_CAPACITY = 255
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [brf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [brf_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                             req_valid,
    input  logic                             req_operation,
    input  logic                             req_last,
    output logic                             req_ready,
    input  logic [brf_pkg::DATA_W-1:0]       head_data,
    output brf_pkg::cell_ctl_t               cell_ctl,
    output brf_pkg::rsp_t                    rsp,
    output logic                             rsp_valid,
    input  logic                             rsp_ready
);

    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int EW = (CW > 8) ? CW : 8;

    logic [7:0]          capacity_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [7:0]          tally_reg;
    logic [7:0]          tally_next;
    logic [7:0]          tally_inc;
    logic                up_reg;

    brf_pkg::rsp_t       out_reg;
    brf_pkg::rsp_t       skid_reg;
    brf_pkg::rsp_t       result;
    logic                out_valid_reg;
    logic                skid_valid_reg;

    logic                cfg_wr;
    logic                push;
    logic                pop;
    logic                is_read;
    logic                can_read;
    logic                can_write;
    logic                moved;
    logic [EW-1:0]       cap_w;
    logic [EW-1:0]       cap_eff_w;
    logic [CW-1:0]       cap_eff;
    logic [CW-1:0]       free_c;
    logic [EW-1:0]       count_w;
    logic [EW-1:0]       free_w;

    // apb: pready tied high, register index from paddr[2]
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == brf_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == brf_pkg::REG_CAPACITY)
                    ? {{(brf_pkg::APB_DATA_W-8){1'b0}}, capacity_reg}
                    : '0;

    assign cap_w     = EW'(capacity_reg);
    assign cap_eff_w = (cap_w < EW'(MAX_CAPACITY)) ? cap_w : EW'(MAX_CAPACITY);
    assign cap_eff   = cap_eff_w[CW-1:0];

    assign req_ready = up_reg && !skid_valid_reg;
    assign push      = req_valid && req_ready;
    assign pop       = out_valid_reg && rsp_ready;

    assign is_read   = (req_operation == brf_pkg::OP_READ);
    assign can_read  = (count_reg != '0);
    assign can_write = (count_reg < cap_eff);
    assign moved     = is_read ? can_read : can_write;

    always_comb
    begin
        count_next = count_reg;
        if (moved)
        begin
            count_next = is_read ? (count_reg - CW'(1)) : (count_reg + CW'(1));
        end
    end

    assign tally_inc  = (moved && (tally_reg != brf_pkg::TALLY_MAX))
                        ? (tally_reg + 8'd1) : tally_reg;
    assign tally_next = req_last ? 8'd0 : tally_inc;

    assign free_c  = cap_eff - count_next;
    assign count_w = EW'(count_next);
    assign free_w  = EW'(free_c);

    always_comb
    begin
        result.accepted         = moved;
        result.read_data        = (moved && is_read) ? head_data : '0;
        result.stored_count     = count_w[7:0];
        result.free_count       = free_w[7:0];
        result.is_empty         = (count_next == '0);
        result.is_full          = (count_next == cap_eff);
        result.moved_in_request = tally_inc;
    end

    assign cell_ctl.clear = cfg_wr;
    assign cell_ctl.shift = push && is_read && can_read;
    assign cell_ctl.load  = push && !is_read && can_write;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= brf_pkg::CAP_RESET;
            count_reg      <= '0;
            tally_reg      <= '0;
            up_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            up_reg <= 1'b1;
            if (cfg_wr)
            begin
                capacity_reg <= pwdata[7:0];
                count_reg    <= '0;
                tally_reg    <= '0;
            end
            else if (push)
            begin
                count_reg <= count_next;
                tally_reg <= tally_next;
            end

            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                if (out_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

endmodule

// ----- rtl/core/brf_checker.sv -----
// ----------------------------------------------------------------------------
// brf_checker
// port-level checks of the byte ring fifo core, bound to the top level
// ----------------------------------------------------------------------------
module brf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       rsp_accepted,
    input logic [7:0] rsp_read_data,
    input logic [7:0] rsp_stored_count,
    input logic [7:0] rsp_free_count,
    input logic       rsp_is_empty,
    input logic       rsp_is_full
);

    // no result word may come out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("rsp word valid right after reset");

    // a stalled result word stays valid and holds its read data, stored count and accepted flag
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
            && $stable(rsp_stored_count) && $stable(rsp_accepted))
        else $error("stalled rsp word changed");

    // a refused operation returns no data
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_accepted |-> rsp_read_data == 8'd0)
        else $error("refused word carries read data");

    // empty and full together only with zero capacity
    a_zero_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty && rsp_is_full
            |-> rsp_stored_count == 8'd0 && rsp_free_count == 8'd0
                && !rsp_accepted)
        else $error("empty and full with nonzero counts");

endmodule

bind byte_ring_fifo_core brf_checker u_brf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_accepted     (rsp.accepted),
    .rsp_read_data    (rsp.read_data),
    .rsp_stored_count (rsp.stored_count),
    .rsp_free_count   (rsp.free_count),
    .rsp_is_empty     (rsp.is_empty),
    .rsp_is_full      (rsp.is_full)
);
